// ----- sv/mexp_pkg.sv -----
// package for the modular exponentiation unit: field widths and beat types
// no dependencies; used by modular_exponentiation_unit
`default_nettype none

package mexp_pkg;

  localparam int unsigned OPERAND_WIDTH  = 32;
  localparam int unsigned EXPONENT_WIDTH = 63;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0]  base_value;
    logic [EXPONENT_WIDTH-1:0] exponent;
    logic [OPERAND_WIDTH-1:0]  modulus;
  } in_beat_t;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] power_result;
    logic                     mod_error;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- sv/modular_exponentiation_unit.sv -----
// modular exponentiation unit: base^exponent mod modulus, square-and-multiply
// depends on mexp_pkg for the beat types and field widths
`default_nettype none

// usage
// - input channel in_valid_i / in_stall_o / in_data_i carries one beat with
//   base_value, exponent and modulus; a beat is taken when valid is high and
//   stall is low
// - output channel out_valid_o / out_stall_i / out_data_o returns one beat per
//   input beat with power_result and mod_error
// - one shared modular multiplier does all the work: it scans one multiplier
//   bit per cycle (double, reduce, add, reduce)
// - a zero modulus or a zero exponent goes straight to the result; otherwise
//   one base reduction, one multiply per set exponent bit and one squaring per
//   exponent bit below the highest set bit run on the shared multiplier
// - throughput: one beat at a time; in_stall_o is high while a beat is in work
// - the result sits in an output register, so a new beat is taken while an
//   earlier result still waits; a finished result waits for that register to
//   free up when the receiver stalls
// - reset clears the sequencer and the output valid; no state carries across
//   beats
module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_BITS  = 32,
  parameter int unsigned EXPONENT_BITS = 63
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire mexp_pkg::in_beat_t in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output mexp_pkg::out_beat_t out_data_o
);

  localparam int unsigned W      = OPERAND_BITS;
  localparam int unsigned E      = EXPONENT_BITS;
  localparam int unsigned CntW   = (W > 1) ? $clog2(W) : 1;
  localparam int unsigned FieldW = mexp_pkg::OPERAND_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [W-1:0]        mod_q, mod_d;       // modulus
  logic [E-1:0]        exp_q, exp_d;       // remaining exponent bits
  logic [W-1:0]        base_q, base_d;     // current base power
  logic [W-1:0]        acc_q, acc_d;       // running result
  logic                err_q, err_d;
  logic [W-1:0]        rem_q, rem_d;       // partial product, always below modulus
  logic [W-1:0]        mplr_q, mplr_d;     // multiplier bits, msb first
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  mexp_pkg::out_beat_t out_data_q, out_data_d;

  // shared multiplier step
  logic [W-1:0] addend;
  logic [W:0]   dbl, dbl_red, sum;
  logic [W-1:0] rem_step;
  logic         last_step;
  logic         slot_free;
  logic [W-1:0] new_base;
  logic [E-1:0] exp_shift;

  logic [W-1:0] in_base, in_mod;
  logic [E-1:0] in_exp;

  assign in_base = in_data_i.base_value[W-1:0];
  assign in_mod  = in_data_i.modulus[W-1:0];
  assign in_exp  = in_data_i.exponent[E-1:0];

  // base reduction multiplies by one, so the addend stays at most the modulus
  assign addend    = (state_q == ST_REDUCE) ? W'(1) : base_q;
  assign dbl       = {rem_q, 1'b0};
  assign dbl_red   = (dbl >= {1'b0, mod_q}) ? (dbl - {1'b0, mod_q}) : dbl;
  assign sum       = {1'b0, dbl_red[W-1:0]} + (mplr_q[W-1] ? {1'b0, addend} : '0);
  assign rem_step  = (sum >= {1'b0, mod_q}) ? W'(sum - {1'b0, mod_q}) : sum[W-1:0];
  assign last_step = (cnt_q == CntW'(W - 1));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign new_base  = (state_q == ST_MUL) ? base_q : rem_step;
  assign exp_shift = exp_q >> 1;

  always_comb begin
    state_d     = state_q;
    mod_d       = mod_q;
    exp_d       = exp_q;
    base_d      = base_q;
    acc_d       = acc_q;
    err_d       = err_q;
    rem_d       = rem_q;
    mplr_d      = mplr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mod_d  = in_mod;
          exp_d  = in_exp;
          acc_d  = W'(1);
          err_d  = 1'b0;
          rem_d  = '0;
          mplr_d = in_base;
          cnt_d  = '0;
          if (in_mod == '0) begin
            err_d   = 1'b1;
            acc_d   = '0;
            state_d = ST_DONE;
          end else if (in_exp == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        rem_d  = rem_step;
        mplr_d = mplr_q << 1;
        cnt_d  = cnt_q + CntW'(1);
        if (last_step) begin
          rem_d = '0;
          cnt_d = '0;
          if (state_q == ST_MUL) begin
            acc_d = rem_step;
          end else begin
            base_d = rem_step;
          end
          if (state_q != ST_MUL && exp_q[0]) begin
            mplr_d  = acc_q;
            state_d = ST_MUL;
          end else begin
            exp_d = exp_shift;
            if (exp_shift != '0) begin
              mplr_d  = new_base;
              state_d = ST_SQR;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d             = 1'b1;
          out_data_d.power_result = FieldW'(acc_q);
          out_data_d.mod_error    = err_q;
          state_d                 = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      mod_q       <= '0;
      exp_q       <= '0;
      base_q      <= '0;
      acc_q       <= '0;
      err_q       <= 1'b0;
      rem_q       <= '0;
      mplr_q      <= '0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      mod_q       <= mod_d;
      exp_q       <= exp_d;
      base_q      <= base_d;
      acc_q       <= acc_d;
      err_q       <= err_d;
      rem_q       <= rem_d;
      mplr_q      <= mplr_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // an accepted beat keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  // partial product stays reduced during every multiplication
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR)
      |-> rem_q < mod_q)
    else $error("partial product not below modulus");

  // base power is reduced once the reduction pass is over
  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_SQR) |-> base_q < mod_q)
    else $error("base power not below modulus");

  // a finished result with a free output register shows up next cycle
  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && slot_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished result not issued");

  // an error result always carries zero
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mod_error |-> out_data_o.power_result == '0)
    else $error("error beat with nonzero result");
`endif

endmodule

`default_nettype wire
